>>> hdl/hsv2rgb_pkg.sv
// hsv2rgb_pkg: constants, sector codes and stage payload types for the
// HSV to RGB565 pixel pipeline. No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  localparam int unsigned HueW      = 10;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned RgbW      = 16;
  localparam int unsigned FullCircle = 360;
  localparam int unsigned SectorSpan = 60;
  localparam int unsigned LevelMax   = 255;
  localparam int unsigned FracDen    = SectorSpan * LevelMax;  // 15300
  // floor(2^24 / 15300); estimate is low by at most one
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipMul   = (1 << RecipShift) / FracDen;

  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  // after hue split
  typedef struct packed {
    sector_e     sector;
    logic [5:0]  rem;
    logic [7:0]  sat;
    logic [7:0]  val;
  } sect_t;

  // level numerators and quotient estimates
  typedef struct packed {
    sector_e     sector;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [21:0] xq;
    logic [7:0]  eq;
    logic [21:0] xt;
    logic [7:0]  et;
  } lvl_t;

endpackage

`default_nettype wire

>>> hdl/hsv2rgb_sector.sv
// hsv2rgb_sector: two stages, hue mod 360 then sector / remainder split.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [9:0]            hue_i,
  input  logic [7:0]            sat_i,
  input  logic [7:0]            val_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsv2rgb_pkg::sect_t    out_o
);
  import hsv2rgb_pkg::*;

  logic       v1_q, v2_q;
  logic       en1, en2;
  logic [8:0] h_d, h_q;
  logic [7:0] s1_q, b1_q;
  sect_t      sd_d, sd_q;
  logic [8:0] base;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_comb begin
    if (hue_i >= 10'(2 * FullCircle)) begin
      h_d = 9'(hue_i - 10'(2 * FullCircle));
    end else if (hue_i >= 10'(FullCircle)) begin
      h_d = 9'(hue_i - 10'(FullCircle));
    end else begin
      h_d = 9'(hue_i);
    end
  end

  always_comb begin
    if (h_q >= 9'(5 * SectorSpan)) begin
      sd_d.sector = SEC_M_R;
    end else if (h_q >= 9'(4 * SectorSpan)) begin
      sd_d.sector = SEC_B_M;
    end else if (h_q >= 9'(3 * SectorSpan)) begin
      sd_d.sector = SEC_C_B;
    end else if (h_q >= 9'(2 * SectorSpan)) begin
      sd_d.sector = SEC_G_C;
    end else if (h_q >= 9'(SectorSpan)) begin
      sd_d.sector = SEC_Y_G;
    end else begin
      sd_d.sector = SEC_R_Y;
    end
    case (sd_d.sector)
      SEC_R_Y: base = 9'd0;
      SEC_Y_G: base = 9'(SectorSpan);
      SEC_G_C: base = 9'(2 * SectorSpan);
      SEC_C_B: base = 9'(3 * SectorSpan);
      SEC_B_M: base = 9'(4 * SectorSpan);
      default: base = 9'(5 * SectorSpan);
    endcase
    sd_d.rem = 6'(h_q - base);
    sd_d.sat = s1_q;
    sd_d.val = b1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      h_q  <= h_d;
      s1_q <= sat_i;
      b1_q <= val_i;
    end
    if (en2) sd_q <= sd_d;
  end

  assign out_valid_o = v2_q;
  assign out_o       = sd_q;

endmodule

`default_nettype wire

>>> hdl/hsv2rgb_level.sv
// hsv2rgb_level: three stages forming p, and the q / t numerators with
// reciprocal quotient estimates. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_level (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hsv2rgb_pkg::sect_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hsv2rgb_pkg::lvl_t   out_o
);
  import hsv2rgb_pkg::*;

  logic        v3_q, v4_q, v5_q;
  logic        en3, en4, en5;
  // stage 3
  sector_e     sec3_q;
  logic [7:0]  val3_q, ns_q;
  logic [13:0] a_q, b_q;
  logic [13:0] srem, scomp;
  // stage 4
  sector_e     sec4_q;
  logic [7:0]  val4_q;
  logic [15:0] xp_q;
  logic [21:0] xq_q, xt_q;
  // stage 5
  logic [16:0] xp1, psum;
  logic [32:0] pq, pt;
  lvl_t        lv_d, lv_q;

  assign en5        = !v5_q || out_ready_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  assign srem  = 14'(in_i.sat) * 14'(in_i.rem);
  assign scomp = 14'(in_i.sat) * 14'(6'(SectorSpan) - in_i.rem);

  // floor(x / 255) for x < 65535
  assign xp1  = 17'(xp_q) + 17'd1;
  assign psum = xp1 + (xp1 >> 8);
  assign pq   = 33'(xq_q) * 33'(RecipMul);
  assign pt   = 33'(xt_q) * 33'(RecipMul);

  always_comb begin
    lv_d.sector = sec4_q;
    lv_d.val    = val4_q;
    lv_d.p      = psum[15:8];
    lv_d.xq     = xq_q;
    lv_d.eq     = pq[RecipShift +: 8];
    lv_d.xt     = xt_q;
    lv_d.et     = pt[RecipShift +: 8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) v3_q <= in_valid_i;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sec3_q <= in_i.sector;
      val3_q <= in_i.val;
      ns_q   <= 8'(LevelMax) - in_i.sat;
      a_q    <= 14'(FracDen) - srem;
      b_q    <= 14'(FracDen) - scomp;
    end
    if (en4) begin
      sec4_q <= sec3_q;
      val4_q <= val3_q;
      xp_q   <= 16'(val3_q) * 16'(ns_q);
      xq_q   <= 22'(val3_q) * 22'(a_q);
      xt_q   <= 22'(val3_q) * 22'(b_q);
    end
    if (en5) lv_q <= lv_d;
  end

  assign out_valid_o = v5_q;
  assign out_o       = lv_q;

endmodule

`default_nettype wire

>>> hdl/hsv2rgb_pack.sv
// hsv2rgb_pack: quotient correction, sector channel select and RGB565
// packing into the output register. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::lvl_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        rgb565_o
);
  import hsv2rgb_pkg::*;

  logic        v6_q, en6;
  logic [21:0] rq, rt;
  logic [7:0]  q, t, red, grn, blu;
  logic [15:0] rgb_d, rgb_q;

  assign en6        = !v6_q || out_ready_i;
  assign in_ready_o = en6;

  assign rq = in_i.xq - 22'(in_i.eq) * 22'(FracDen);
  assign rt = in_i.xt - 22'(in_i.et) * 22'(FracDen);
  assign q  = in_i.eq + 8'(rq >= 22'(FracDen));
  assign t  = in_i.et + 8'(rt >= 22'(FracDen));

  always_comb begin
    case (in_i.sector)
      SEC_R_Y: begin red = in_i.val; grn = t;        blu = in_i.p;   end
      SEC_Y_G: begin red = q;        grn = in_i.val; blu = in_i.p;   end
      SEC_G_C: begin red = in_i.p;   grn = in_i.val; blu = t;        end
      SEC_C_B: begin red = in_i.p;   grn = q;        blu = in_i.val; end
      SEC_B_M: begin red = t;        grn = in_i.p;   blu = in_i.val; end
      default: begin red = in_i.val; grn = in_i.p;   blu = q;        end
    endcase
    rgb_d = {red[7:3], grn[7:2], blu[7:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en6) begin
      v6_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) rgb_q <= rgb_d;
  end

  assign out_valid_o = v6_q;
  assign rgb565_o    = rgb_q;

endmodule

`default_nettype wire

>>> hdl/hsv_to_rgb565.sv
// hsv_to_rgb565: top level of the HSV to RGB565 pixel pipeline.
// Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_level, hsv2rgb_pack.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+----------------------------------
//   in      | in_valid_i  | in_ready_o  | hue_i, saturation_i, brightness_i
//   out     | out_valid_o | out_ready_i | rgb565_o
//
// Six register stages; one pixel per clock while the output is not stalled.
// Depth is set by the two multiply levels and the reciprocal divide
// with its one-step correction.
// Reset clears only the stage valid bits; the data registers are not reset.
// Each stage advances when it is empty or the next one advances, so a
// stall fills bubbles first and drops or repeats no transfer.
`default_nettype none

module hsv_to_rgb565 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [9:0]  hue_i,
  input  logic [7:0]  saturation_i,
  input  logic [7:0]  brightness_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] rgb565_o
);
  import hsv2rgb_pkg::*;

  logic  sv_valid, sv_ready, lv_valid, lv_ready;
  sect_t sect;
  lvl_t  lvl;

  hsv2rgb_sector u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hue_i       (hue_i),
    .sat_i       (saturation_i),
    .val_i       (brightness_i),
    .out_valid_o (sv_valid),
    .out_ready_i (sv_ready),
    .out_o       (sect)
  );

  hsv2rgb_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sv_valid),
    .in_ready_o  (sv_ready),
    .in_i        (sect),
    .out_valid_o (lv_valid),
    .out_ready_i (lv_ready),
    .out_o       (lvl)
  );

  hsv2rgb_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lv_valid),
    .in_ready_o  (lv_ready),
    .in_i        (lvl),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rgb565_o    (rgb565_o)
  );

endmodule

`default_nettype wire

>>> hdl/hsv_to_rgb565_chk.sv
// hsv_to_rgb565_chk: port-level checks for hsv_to_rgb565, bound to the top.
// Depends on hsv_to_rgb565 port names only.
`default_nettype none

module hsv_to_rgb565_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [9:0]  hue_i,
  input logic [7:0]  saturation_i,
  input logic [7:0]  brightness_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] rgb565_o
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rgb565_o))
    else $error("stalled result changed");

  // free output means the pipe takes a new transfer
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked while output free");

  // input only blocks behind a stalled output
  a_ready_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

endmodule

bind hsv_to_rgb565 hsv_to_rgb565_chk u_chk (.*);

`default_nettype wire

>>> verif/hsv_to_rgb565_tb.sv
// hsv_to_rgb565_tb: self-checking testbench for the HSV to RGB565 pixel pipeline.
// Checks every output transfer against an integer HSV model under random stalls.
// Depends on hsv2rgb_pkg and hsv_to_rgb565.
`timescale 1ns / 100ps

module hsv_to_rgb565_tb;
  import hsv2rgb_pkg::*;

  typedef struct {
    logic [9:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    int unsigned rest;
    bit          drain;
  } pixel_t;

  typedef struct {
    logic [15:0] rgb;
    logic [9:0]  hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } color_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [9:0]  hue_i = '0;
  logic [7:0]  saturation_i = '0;
  logic [7:0]  brightness_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] rgb565_o;

  pixel_t      pixel_q[$];
  color_t      color_q[$];
  pixel_t      tx_pix;
  color_t      want_c;
  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;
  int unsigned sent_cnt = 0;
  int unsigned mismatch_cnt = 0;

  hsv_to_rgb565 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rgb565_o     (rgb565_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // exact integer HSV to RGB565
  function automatic logic [15:0] rgb565_of(logic [9:0] hue, logic [7:0] sat,
                                            logic [7:0] val);
    logic [31:0] h, r, s, v, p, q, t, red, grn, blu;
    h = 32'(hue) % FullCircle;
    r = h % SectorSpan;
    s = 32'(sat);
    v = 32'(val);
    p = (v * (LevelMax - s)) / LevelMax;
    q = (v * (FracDen - s * r)) / FracDen;
    t = (v * (FracDen - s * (SectorSpan - r))) / FracDen;
    case (sector_e'(3'(h / SectorSpan)))
      SEC_R_Y: begin red = v; grn = t; blu = p; end
      SEC_Y_G: begin red = q; grn = v; blu = p; end
      SEC_G_C: begin red = p; grn = v; blu = t; end
      SEC_C_B: begin red = p; grn = q; blu = v; end
      SEC_B_M: begin red = t; grn = p; blu = v; end
      default: begin red = v; grn = p; blu = q; end
    endcase
    return {red[7:3], grn[7:2], blu[7:3]};
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_level();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val,
                           int unsigned rest, bit drain);
    pixel_t pix;
    pix.hue = 10'(hue);
    pix.sat = 8'(sat);
    pix.val = 8'(val);
    pix.rest = rest;
    pix.drain = drain;
    pixel_q.push_back(pix);
  endtask

  // sender: next transfer offered at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold until transfer
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pixel_q.size() != 0 && !(pixel_q[0].drain && color_q.size() != 0)) begin
      tx_pix = pixel_q.pop_front();
      hue_i <= tx_pix.hue;
      saturation_i <= tx_pix.sat;
      brightness_i <= tx_pix.val;
      in_valid_i <= 1'b1;
      gap_left <= tx_pix.rest;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver backpressure, with calm stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (calm_left != 0) begin
      out_ready_i <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(100, 400);
      else if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // monitor: record input transfers, check output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        want_c.rgb = rgb565_of(hue_i, saturation_i, brightness_i);
        want_c.hue = hue_i;
        want_c.sat = saturation_i;
        want_c.val = brightness_i;
        color_q.push_back(want_c);
        sent_cnt <= sent_cnt + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (color_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected transfer: rgb565 %h", rgb565_o);
        end else begin
          want_c = color_q.pop_front();
          if (rgb565_o !== want_c.rgb) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("rgb565 mismatch: hue %0d sat %0d val %0d expected %h got %h",
                       want_c.hue, want_c.sat, want_c.val, want_c.rgb, rgb565_o);
          end
        end
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned rest;
    // sector edges, hue wrap, grey, black
    add_pixel(0, 255, 255, 0, 1'b0);
    add_pixel(59, 255, 255, 0, 1'b0);
    add_pixel(60, 255, 255, 1, 1'b0);
    add_pixel(119, 255, 200, 0, 1'b0);
    add_pixel(120, 255, 255, 0, 1'b0);
    add_pixel(180, 255, 255, 2, 1'b0);
    add_pixel(240, 255, 255, 0, 1'b0);
    add_pixel(300, 255, 255, 0, 1'b0);
    add_pixel(359, 255, 255, 0, 1'b0);
    add_pixel(360, 255, 255, 3, 1'b0);
    add_pixel(719, 128, 255, 0, 1'b0);
    add_pixel(720, 255, 255, 0, 1'b0);
    add_pixel(1023, 255, 255, 0, 1'b0);
    add_pixel(30, 0, 255, 0, 1'b0);
    add_pixel(200, 0, 128, 0, 1'b0);
    add_pixel(90, 255, 0, 0, 1'b0);
    add_pixel(1023, 0, 0, 0, 1'b0);
    add_pixel(45, 1, 255, 0, 1'b0);
    add_pixel(330, 254, 1, 0, 1'b0);
    add_pixel(512, 170, 85, 0, 1'b0);
    for (int i = 0; i < 2000; i++) begin
      rest = ((i / 150) % 3 == 2) ? 0 : idle_len();
      add_pixel($urandom_range(0, 1023), rand_level(), rand_level(), rest,
                i == 0 || i == 1000 || i == 1500);
    end
    total = pixel_q.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (sent_cnt != total) @(posedge clk_i);
    while (color_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** hsv_to_rgb565: PASSED **");
    end else begin
      $display("** hsv_to_rgb565: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout: %0d transfers still expected", color_q.size());
    $display("** hsv_to_rgb565: FAILED **");
    $finish;
  end

endmodule
